/* hw/rtl/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* hw/rtl/ppl_pkg.sv */
// types, constants and helper functions of the position pid loop
`timescale 1ns / 1ps

package ppl_pkg;

    localparam int DW   = 32;
    localparam int FB   = 16;
    localparam int IDXW = 3;
    localparam int CW   = $clog2(DW + 1);

    typedef logic signed [DW-1:0] word_t;
    typedef logic        [DW-1:0] uword_t;

    // register indexes
    localparam logic [IDXW-1:0] REG_GAIN_P  = 3'd0;
    localparam logic [IDXW-1:0] REG_GAIN_I  = 3'd1;
    localparam logic [IDXW-1:0] REG_GAIN_D  = 3'd2;
    localparam logic [IDXW-1:0] REG_CMD_HI  = 3'd3;
    localparam logic [IDXW-1:0] REG_CMD_LO  = 3'd4;
    localparam logic [IDXW-1:0] REG_POS_HI  = 3'd5;
    localparam logic [IDXW-1:0] REG_POS_LO  = 3'd6;

    // limit flag codes
    localparam logic [1:0] LIM_NONE  = 2'd0;
    localparam logic [1:0] LIM_UPPER = 2'd1;
    localparam logic [1:0] LIM_LOWER = 2'd2;

    // function codes
    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam word_t WORD_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic   load;
        uword_t a_mag;
        uword_t b_mag;
        logic   neg;
    } mul_req_t;

    typedef struct packed {
        logic                start;
        logic signed [DW:0]  num;
        uword_t              den;
    } div_req_t;

    // magnitude of a signed word, the most negative value included
    function automatic uword_t mag_w(input word_t x);
        return x[DW-1] ? uword_t'(-x) : uword_t'(x);
    endfunction

    // signed word from magnitude and sign, saturated
    function automatic word_t sat_mag(input logic [2*DW-1:0] m, input logic neg);
        logic [2*DW-1:0] lim;
        logic [2*DW-1:0] mm;
        logic [DW-1:0]   low;
        lim = neg ? ((2*DW)'(1) << (DW-1)) : (((2*DW)'(1) << (DW-1)) - (2*DW)'(1));
        mm  = (m > lim) ? lim : m;
        low = mm[DW-1:0];
        return neg ? word_t'(-low) : word_t'(low);
    endfunction

    // saturate a value two bits wider than a word
    function automatic word_t sat_wide(input logic signed [DW+1:0] x);
        logic signed [DW+1:0] hi_w;
        logic signed [DW+1:0] lo_w;
        hi_w = {{2{WORD_MAX[DW-1]}}, WORD_MAX};
        lo_w = {{2{WORD_MIN[DW-1]}}, WORD_MIN};
        if (x > hi_w)
            return WORD_MAX;
        else if (x < lo_w)
            return WORD_MIN;
        else
            return x[DW-1:0];
    endfunction

    // sign extend a word by two bits
    function automatic logic signed [DW+1:0] ext2(input word_t x);
        return {{2{x[DW-1]}}, x};
    endfunction

endpackage

/* hw/rtl/ppl_mul.sv */
// shared fixed point multiplier, registered product with shift and saturation
`timescale 1ns / 1ps

module ppl_mul
    import ppl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output word_t    result
);

    logic [2*DW-1:0] prod_reg;
    logic            neg_reg;
    logic            loaded_reg;

    // magnitudes multiplied exactly, sign kept aside
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            prod_reg <= (2*DW)'(req.a_mag) * (2*DW)'(req.b_mag);
            neg_reg  <= req.neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loaded_reg <= 1'b0;
        else if (req.load)
            loaded_reg <= 1'b1;
    end

    // drop fraction bits toward zero, then saturate
    assign result = loaded_reg
                  ? sat_mag({{FB{1'b0}}, prod_reg[2*DW-1:FB]}, neg_reg)
                  : '0;

endmodule

/* hw/rtl/ppl_div.sv */
// serial restoring divider for the derivative term, one quotient bit a cycle
`timescale 1ns / 1ps

module ppl_div
    import ppl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output logic     busy,
    output word_t    quotient
);

    logic            busy_reg;
    logic [CW-1:0]   cnt_reg;
    logic [DW-1:0]   rem_reg;
    uword_t          dq_reg;
    uword_t          den_reg;
    logic            neg_reg;
    logic            ovf_reg;
    logic            zero_reg;

    logic [DW:0]     num_mag;
    logic [DW:0]     num_hi;
    logic [DW:0]     rem_shift;
    logic            rem_ge;

    assign num_mag   = req.num[DW] ? (DW+1)'(-req.num) : (DW+1)'(req.num);
    assign num_hi    = num_mag >> (DW - FB);
    assign rem_shift = {rem_reg, dq_reg[DW-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start && !busy_reg)
        begin
            if (req.den != '0 && num_hi < {1'b0, req.den})
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            neg_reg  <= req.num[DW];
            den_reg  <= req.den;
            zero_reg <= (req.den == '0);
            // quotient would not fit a word
            ovf_reg  <= (num_hi >= {1'b0, req.den});
            rem_reg  <= num_hi[DW-1:0];
            dq_reg   <= {num_mag[DW-FB-1:0], {FB{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_ge ? DW'(rem_shift - {1'b0, den_reg}) : rem_shift[DW-1:0];
            dq_reg  <= {dq_reg[DW-2:0], rem_ge};
        end
    end

    assign busy = busy_reg;

    always_comb
    begin
        if (zero_reg)
            quotient = '0;
        else if (ovf_reg)
            quotient = sat_mag({(2*DW){1'b1}}, neg_reg);
        else
            quotient = sat_mag({{DW{1'b0}}, dq_reg}, neg_reg);
    end

endmodule

/* hw/rtl/pid_position_loop.sv */
// position pid loop top level: registers, sequencer and output stage
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Position PID controller in signed Q16.16. A start transfer (func 0) clears
// the stored error and integral, latches the timestamp and gives no result; it
// is taken without leaving S_IDLE. An update transfer (func 1) runs a small
// sequencer over one shared 32x32 multiplier and a serial divider: the error
// times elapsed time is integrated and clamped to the command limits, the
// error change is divided by the elapsed time (derivative zero when no time
// has passed), and the three gain terms are summed, clamped to the command
// limits and zeroed outside the position limits. The derivative multiply waits
// for the 32-step divider, which runs one quotient bit a cycle alongside the
// multiplies, and the next input can be taken as soon as the result is valid;
// with zero elapsed time, or when the derivative quotient saturates, the
// divider is skipped and the derivative multiply does not wait. in_ready is
// low while an update is in flight. The result sits in an output register, so
// a new input may be taken while it waits. The user must write configuration
// through cfg_write/cfg_index/cfg_data only while idle; the block itself does
// not enforce it. Indexes beyond the last register are ignored.
module pid_position_loop
    import ppl_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,

    input  logic            cfg_write,
    input  logic [IDXW-1:0] cfg_index,
    input  logic [DW-1:0]   cfg_data,

    input  logic            in_valid,
    output logic            in_ready,
    input  logic            func,
    input  word_t           target_pos,
    input  word_t           current_pos,
    input  uword_t          timestamp,

    output logic            out_valid,
    input  logic            out_ready,
    output word_t           command,
    output logic [1:0]      torque_limit,
    output logic [1:0]      position_limit
);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for an input transfer
    localparam logic [2:0] S_MI   = 3'd1;   // error times elapsed issued
    localparam logic [2:0] S_INT  = 3'd2;   // integral update, divider start
    localparam logic [2:0] S_MP   = 3'd3;   // proportional term back
    localparam logic [2:0] S_MIN  = 3'd4;   // integral term back
    localparam logic [2:0] S_WDIV = 3'd5;   // waiting on derivative quotient
    localparam logic [2:0] S_MD   = 3'd6;   // derivative term back, result out

    // configuration
    word_t gain_p_reg, gain_i_reg, gain_d_reg;
    word_t cmd_hi_reg, cmd_lo_reg, pos_hi_reg, pos_lo_reg;

    // loop state
    logic [2:0] state_reg, state_next;
    word_t      prev_error_reg, prev_error_next;
    word_t      integral_reg, integral_next;
    uword_t     prev_time_reg, prev_time_next;

    // per update working values
    word_t                err_reg, err_next;
    uword_t               elapsed_reg, elapsed_next;
    word_t                pos_reg, pos_next;
    logic signed [DW+1:0] acc_reg, acc_next;

    // output stage
    logic       out_valid_reg, out_valid_next;
    word_t      command_reg, command_next;
    logic [1:0] tflag_reg, tflag_next;
    logic [1:0] pflag_reg, pflag_next;

    // shared units
    mul_req_t mul_req;
    word_t    mul_res;
    div_req_t div_req;
    logic     div_busy;
    word_t    div_q;

    logic in_xfer;

    ppl_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .result (mul_res)
    );

    ppl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // configuration writes, out of range indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            cmd_hi_reg <= WORD_MAX;
            cmd_lo_reg <= WORD_MIN;
            pos_hi_reg <= WORD_MAX;
            pos_lo_reg <= WORD_MIN;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN_P: gain_p_reg <= cfg_data;
                REG_GAIN_I: gain_i_reg <= cfg_data;
                REG_GAIN_D: gain_d_reg <= cfg_data;
                REG_CMD_HI: cmd_hi_reg <= cfg_data;
                REG_CMD_LO: cmd_lo_reg <= cfg_data;
                REG_POS_HI: pos_hi_reg <= cfg_data;
                REG_POS_LO: pos_lo_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        logic signed [DW+1:0] diff;
        logic signed [DW+1:0] isum;
        word_t                isat;
        logic signed [DW+1:0] csum;
        logic signed [DW+1:0] chi_w;
        logic signed [DW+1:0] clo_w;

        diff  = ext2(target_pos) - ext2(current_pos);
        isum  = ext2(integral_reg) + ext2(mul_res);
        isat  = sat_wide(isum);
        csum  = acc_reg + ext2(mul_res);
        chi_w = ext2(cmd_hi_reg);
        clo_w = ext2(cmd_lo_reg);

        state_next      = state_reg;
        prev_error_next = prev_error_reg;
        integral_next   = integral_reg;
        prev_time_next  = prev_time_reg;
        err_next        = err_reg;
        elapsed_next    = elapsed_reg;
        pos_next        = pos_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        command_next    = command_reg;
        tflag_next      = tflag_reg;
        pflag_next      = pflag_reg;

        mul_req       = '0;
        div_req       = '0;
        div_req.num   = {err_reg[DW-1], err_reg} - {prev_error_reg[DW-1], prev_error_reg};
        div_req.den   = elapsed_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    prev_time_next = timestamp;
                    if (func == FUNC_START)
                    begin
                        prev_error_next = '0;
                        integral_next   = '0;
                    end
                    else
                    begin
                        // elapsed time wraps with the timestamp
                        err_next     = sat_wide(diff);
                        elapsed_next = timestamp - prev_time_reg;
                        pos_next     = current_pos;
                        state_next   = S_MI;
                    end
                end
            end
            S_MI:
            begin
                mul_req.load  = 1'b1;
                mul_req.a_mag = mag_w(err_reg);
                mul_req.b_mag = elapsed_reg;
                mul_req.neg   = err_reg[DW-1];
                state_next    = S_INT;
            end
            S_INT:
            begin
                // anti-windup clamp, upper test first
                if (isat > cmd_hi_reg)
                    integral_next = cmd_hi_reg;
                else if (isat < cmd_lo_reg)
                    integral_next = cmd_lo_reg;
                else
                    integral_next = isat;
                div_req.start = 1'b1;
                mul_req.load  = 1'b1;
                mul_req.a_mag = mag_w(gain_p_reg);
                mul_req.b_mag = mag_w(err_reg);
                mul_req.neg   = gain_p_reg[DW-1] ^ err_reg[DW-1];
                state_next    = S_MP;
            end
            S_MP:
            begin
                acc_next      = ext2(mul_res);
                mul_req.load  = 1'b1;
                mul_req.a_mag = mag_w(gain_i_reg);
                mul_req.b_mag = mag_w(integral_reg);
                mul_req.neg   = gain_i_reg[DW-1] ^ integral_reg[DW-1];
                state_next    = S_MIN;
            end
            S_MIN:
            begin
                acc_next   = csum;
                state_next = S_WDIV;
            end
            S_WDIV:
            begin
                if (!div_busy)
                begin
                    mul_req.load  = 1'b1;
                    mul_req.a_mag = mag_w(gain_d_reg);
                    mul_req.b_mag = mag_w(div_q);
                    mul_req.neg   = gain_d_reg[DW-1] ^ div_q[DW-1];
                    state_next    = S_MD;
                end
            end
            S_MD:
            begin
                // hold here while an earlier result still waits
                if (!out_valid_reg || out_ready)
                begin
                    if (csum > chi_w)
                    begin
                        command_next = cmd_hi_reg;
                        tflag_next   = LIM_UPPER;
                    end
                    else if (csum < clo_w)
                    begin
                        command_next = cmd_lo_reg;
                        tflag_next   = LIM_LOWER;
                    end
                    else
                    begin
                        command_next = csum[DW-1:0];
                        tflag_next   = LIM_NONE;
                    end
                    // outside the travel window the drive is cut
                    if (pos_reg > pos_hi_reg)
                    begin
                        command_next = '0;
                        pflag_next   = LIM_UPPER;
                    end
                    else if (pos_reg < pos_lo_reg)
                    begin
                        command_next = '0;
                        pflag_next   = LIM_LOWER;
                    end
                    else
                        pflag_next   = LIM_NONE;
                    out_valid_next  = 1'b1;
                    prev_error_next = err_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_error_reg <= '0;
            integral_reg   <= '0;
            prev_time_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_error_reg <= prev_error_next;
            integral_reg   <= integral_next;
            prev_time_reg  <= prev_time_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        elapsed_reg <= elapsed_next;
        pos_reg     <= pos_next;
        acc_reg     <= acc_next;
        command_reg <= command_next;
        tflag_reg   <= tflag_next;
        pflag_reg   <= pflag_next;
    end

    assign out_valid      = out_valid_reg;
    assign command        = command_reg;
    assign torque_limit   = tflag_reg;
    assign position_limit = pflag_reg;

    // divider only runs underneath the multiply steps
    `ASSERT_IMP(a_div_window, clk, rst_n, div_busy,
        state_reg == S_MP || state_reg == S_MIN || state_reg == S_WDIV)

    // a position fault always cuts the drive
    `ASSERT_IMP(a_pos_cut, clk, rst_n, out_valid && position_limit != LIM_NONE,
        command == '0)

    // the torque flag carries defined codes only
    `ASSERT_IMP(a_tflag_code, clk, rst_n, out_valid,
        torque_limit == LIM_NONE || torque_limit == LIM_UPPER || torque_limit == LIM_LOWER)

    // an update transfer closes the input until it is done
    `ASSERT_NXT(a_update_busy, clk, rst_n, in_valid && in_ready && func == FUNC_UPDATE,
        !in_ready)

endmodule
